FILE: hw/rtl/jsu_pkg.sv
// shared types and constants for the json string unescape block
// no dependencies
package jsu_pkg;

  // result status codes
  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // most results one source byte can cause
  localparam int MAX_RESULTS = 3;

  // results caused by one source byte, ready to be sent one per transfer
  typedef struct packed {
    logic [1:0] cnt;     // number of results, 0 to 3
    logic [1:0] status;  // status shared by every result of the bundle
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } bundle_t;

endpackage

FILE: hw/rtl/jsu_in_if.sv
// source byte channel of the json string unescape block
// no dependencies
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       starts_string;

  modport source (output valid, output in_byte, output starts_string, input ready);
  modport sink (input valid, input in_byte, input starts_string, output ready);
endinterface

FILE: hw/rtl/jsu_out_if.sv
// result channel of the json string unescape block
// no dependencies
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, output out_byte, output status, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input status, input last_of_run,
                output ready);
endinterface

FILE: hw/rtl/jsu_decode.sv
// parse phase machine and per-byte decode into a result bundle
// depends on jsu_pkg
module jsu_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      in_byte,
  input  logic            starts_string,
  output jsu_pkg::bundle_t bundle
);

  // parse phases
  localparam logic [2:0] PH_SEEK = 3'd0;
  localparam logic [2:0] PH_STR  = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX  = 3'd3;
  localparam logic [2:0] PH_IDLE = 3'd4;

  // characters of interest
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_NUL   = 8'h00;

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic [11:0] acc;
  logic [11:0] acc_next;
  logic [1:0]  hcnt;
  logic [1:0]  hcnt_next;

  logic [2:0]  cur_phase;
  logic [11:0] cur_acc;
  logic [1:0]  cur_hcnt;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp;

  // hex digit decode, either case
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // a string start restarts parsing before the byte is examined
  always_comb begin
    cur_phase = starts_string ? PH_SEEK : phase;
    cur_acc   = starts_string ? 12'd0 : acc;
    cur_hcnt  = starts_string ? 2'd0 : hcnt;
  end

  assign cp = {cur_acc, hex_val};

  // next state and results for this byte
  always_comb begin
    phase_next    = cur_phase;
    acc_next      = cur_acc;
    hcnt_next     = cur_hcnt;
    bundle        = '0;
    bundle.status = jsu_pkg::ST_DATA;
    unique case (cur_phase)
      PH_SEEK: begin
        if (in_byte == CH_TAB || in_byte == CH_LF || in_byte == CH_CR ||
            in_byte == CH_SPACE) begin
          phase_next = PH_SEEK;
        end else if (in_byte == CH_QUOTE) begin
          phase_next = PH_STR;
        end else begin
          phase_next    = PH_IDLE;
          bundle.cnt    = 2'd1;
          bundle.status = jsu_pkg::ST_ERR;
        end
      end
      PH_STR: begin
        if (in_byte == CH_NUL) begin
          phase_next    = PH_IDLE;
          bundle.cnt    = 2'd1;
          bundle.status = jsu_pkg::ST_ERR;
        end else if (in_byte == CH_QUOTE) begin
          phase_next    = PH_IDLE;
          bundle.cnt    = 2'd1;
          bundle.status = jsu_pkg::ST_DONE;
        end else if (in_byte == CH_BSL) begin
          phase_next = PH_ESC;
        end else begin
          bundle.cnt   = 2'd1;
          bundle.byte0 = in_byte;
        end
      end
      PH_ESC: begin
        phase_next = PH_STR;
        bundle.cnt = 2'd1;
        unique case (in_byte)
          CH_QUOTE, CH_BSL, CH_SLASH: bundle.byte0 = in_byte;
          CH_B: bundle.byte0 = 8'h08;
          CH_F: bundle.byte0 = 8'h0C;
          CH_N: bundle.byte0 = 8'h0A;
          CH_R: bundle.byte0 = 8'h0D;
          CH_T: bundle.byte0 = 8'h09;
          CH_U: begin
            phase_next = PH_HEX;
            acc_next   = 12'd0;
            hcnt_next  = 2'd0;
            bundle.cnt = 2'd0;
          end
          default: begin
            phase_next    = PH_IDLE;
            bundle.status = jsu_pkg::ST_ERR;
          end
        endcase
      end
      PH_HEX: begin
        if (!hex_ok) begin
          phase_next    = PH_IDLE;
          bundle.cnt    = 2'd1;
          bundle.status = jsu_pkg::ST_ERR;
        end else if (cur_hcnt != 2'd3) begin
          acc_next  = {cur_acc[7:0], hex_val};
          hcnt_next = cur_hcnt + 2'd1;
        end else begin
          // fourth digit: emit utf-8 encoding of the code point
          phase_next = PH_STR;
          acc_next   = 12'd0;
          hcnt_next  = 2'd0;
          if (cp < 16'h0080) begin
            bundle.cnt   = 2'd1;
            bundle.byte0 = cp[7:0];
          end else if (cp < 16'h0800) begin
            bundle.cnt   = 2'd2;
            bundle.byte0 = 8'hC0 | {3'b000, cp[10:6]};
            bundle.byte1 = 8'h80 | {2'b00, cp[5:0]};
          end else begin
            bundle.cnt   = 2'd3;
            bundle.byte0 = 8'hE0 | {4'b0000, cp[15:12]};
            bundle.byte1 = 8'h80 | {2'b00, cp[11:6]};
            bundle.byte2 = 8'h80 | {2'b00, cp[5:0]};
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // state registers advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEEK;
      acc   <= 12'd0;
      hcnt  <= 2'd0;
    end else if (fire) begin
      phase <= phase_next;
      acc   <= acc_next;
      hcnt  <= hcnt_next;
    end
  end

  // checks; a bad hex digit parks the parser with the digits still held
  a_hex_count_phase: assert property (@(posedge clk) disable iff (rst)
    hcnt != 2'd0 |-> (phase == PH_HEX || phase == PH_IDLE))
    else $error("digit count set outside hex phase");
  a_acc_phase: assert property (@(posedge clk) disable iff (rst)
    acc != 12'd0 |-> (phase == PH_HEX || phase == PH_IDLE))
    else $error("code point accumulator set outside hex phase");
  a_non_data_single: assert property (@(posedge clk) disable iff (rst)
    fire && bundle.status != jsu_pkg::ST_DATA |=> phase == PH_IDLE)
    else $error("done or error did not park the parser");

endmodule

FILE: hw/rtl/jsu_emit.sv
// result register: holds one bundle and sends its results one transfer at a time
// depends on jsu_pkg, jsu_out_if
module jsu_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  jsu_pkg::bundle_t bundle,
  output logic             take_ready,
  jsu_out_if.source        dst
);

  logic [1:0]       cnt;
  logic [1:0]       idx;
  logic [1:0]       status;
  logic [7:0]       bytes [jsu_pkg::MAX_RESULTS];
  logic             is_last;
  logic             out_fire;

  assign dst.valid       = (cnt != 2'd0);
  assign is_last         = (idx == cnt - 2'd1);
  assign out_fire        = dst.valid && dst.ready;
  assign take_ready      = !dst.valid || (dst.ready && is_last);
  assign dst.status      = status;
  assign dst.last_of_run = is_last;

  // select the pending byte
  always_comb begin
    unique case (idx)
      2'd0:    dst.out_byte = bytes[0];
      2'd1:    dst.out_byte = bytes[1];
      default: dst.out_byte = bytes[2];
    endcase
  end

  // control: load a new bundle or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= bundle.cnt;
      idx <= 2'd0;
    end else if (out_fire && is_last) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (out_fire) begin
      idx <= idx + 2'd1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      status   <= bundle.status;
      bytes[0] <= bundle.byte0;
      bytes[1] <= bundle.byte1;
      bytes[2] <= bundle.byte2;
    end
  end

  // checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    dst.valid |-> idx < cnt)
    else $error("result index past bundle size");
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (rst)
    dst.valid && !is_last |-> !load)
    else $error("new byte taken while results are still pending");
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_fire && !is_last |=> dst.valid && idx == $past(idx) + 2'd1)
    else $error("run of results broken");
  a_non_data_zero: assert property (@(posedge clk) disable iff (rst)
    dst.valid && dst.status != jsu_pkg::ST_DATA |-> dst.out_byte == 8'd0 && is_last)
    else $error("done or error result carries a byte");

endmodule

FILE: hw/rtl/json_string_unescape_utf8.sv
// top level of the json string unescape block
// depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_decode, jsu_emit
//
// Decodes one JSON string literal from a stream of source bytes, one byte per
// transfer on in_ch, into result transfers on out_ch: data bytes (escapes
// resolved, \uXXXX written as one to three UTF-8 bytes), then a done or an
// error result. A byte is decoded in the cycle it is accepted and its results
// land in a result register; while the output is not stalled, a byte that
// causes zero or one result is taken in every cycle, while a byte that causes
// two or three holds the input until the result register has sent them one
// per transfer. The input is taken in the same cycle the final result of the
// previous byte leaves, so a stalled output stalls the input only while
// results are pending. last_of_run marks the final result of each source byte;
// starts_string on a byte restarts parsing at the opening quote search.
module json_string_unescape_utf8 (
  input  logic     clk,
  input  logic     rst,
  jsu_in_if.sink   in_ch,
  jsu_out_if.source out_ch
);

  jsu_pkg::bundle_t bundle;
  logic             fire;
  logic             take_ready;

  // no transfer is taken while reset is held
  assign in_ch.ready = take_ready && !rst;
  assign fire        = in_ch.valid && in_ch.ready;

  // per-byte decode and parse state
  jsu_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .in_byte       (in_ch.in_byte),
    .starts_string (in_ch.starts_string),
    .bundle        (bundle)
  );

  // result register and serializer
  jsu_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .bundle     (bundle),
    .take_ready (take_ready),
    .dst        (out_ch)
  );

endmodule
